// ----- hw/rtl/skts_pkg.sv -----
// Package for the sorted key table search unit.
// Holds command and status codes, beat field widths and parameter defaults.
// No dependencies.
package skts_pkg;

    // Beat field widths.
    localparam int CMD_W       = 2;
    localparam int KEY_W       = 64;
    localparam int POS_W       = 6;
    localparam int STAT_W      = 2;
    localparam int CNT_W       = 7;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 80;

    // Parameter defaults.
    localparam int DEF_CAPACITY = 64;
    localparam int DEF_KEY_BITS = 64;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS    = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd3;

endpackage

// ----- hw/rtl/skts_ram.sv -----
// Generic simple dual-port RAM for the sorted key table search unit.
// One write port and one read port with registered read data.
// No dependencies.
module skts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/sorted_key_table_search_unit.sv -----
// Sorted key table search unit: a command beat in, one result beat out.
// Command on the slave stream; tdata = cmd[1:0], key[65:2], position[71:66].
// Result on the master stream; tdata = status[1:0], found_position[7:2],
// read_key[71:8], entry_count[78:72], bit 79 zero.
// Keys are held in ascending order in one RAM with a registered read port.
// A small sequencer drives that port and compares keys for insert and find.
// Insert walks down from the top entry, moving each entry not less than the
// new key up by one. Find is a binary search with a floor midpoint.
// The unit takes one command at a time; tready is high only while idle.
// A finished result waits in a result stage until the output register is
// free, so a stalled receiver holds the unit, and a new command is taken as
// soon as the result has moved into the output register.
// Reset empties the table at once (entry count zero); the RAM needs no pass.
// Insert into a full table, find miss and read past the count are flagged
// in status and leave the table unchanged.
module sorted_key_table_search_unit
    import skts_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int KEY_BITS = DEF_KEY_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // cmd[1:0], key[65:2], position[71:66]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // status[1:0], found_position[7:2], read_key[71:8], entry_count[78:72], zero[79]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_FND_RD  = 3'd3;
    localparam logic [2:0] S_FND_CMP = 3'd4;
    localparam logic [2:0] S_RD_WAIT = 3'd5;
    localparam logic [2:0] S_FIN     = 3'd6;

    // Input beat fields.
    logic [CMD_W-1:0] in_cmd;
    logic [KEY_W-1:0] in_key;
    logic [POS_W-1:0] in_pos;
    logic             in_accept;

    assign in_cmd    = i_s_axis_tdata[1:0];
    assign in_key    = i_s_axis_tdata[65:2];
    assign in_pos    = i_s_axis_tdata[71:66];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    // Control registers.
    logic [2:0]  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic        r_mvalid, n_mvalid;

    // Working and result registers.
    logic [KEY_BITS-1:0]    r_key, n_key;
    logic [CW-1:0]          r_j, n_j;
    logic [CW-1:0]          r_lo, n_lo;
    logic [CW-1:0]          r_end, n_end;
    logic [CW-1:0]          r_mid, n_mid;
    logic [STAT_W-1:0]      r_status, n_status;
    logic [POS_W-1:0]       r_fpos, n_fpos;
    logic [KEY_BITS-1:0]    r_rkey, n_rkey;
    logic [OUT_TDATA_W-1:0] r_mdata, n_mdata;

    // RAM ports.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    // Binary search midpoint, floor((lo + end - 1) / 2).
    logic [CW:0]   mid_sum;
    logic [CW-1:0] mid;
    logic          out_free;
    logic          rd_ok;

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_end} - {{CW{1'b0}}, 1'b1};
    assign mid      = mid_sum[CW:1];
    assign out_free = !r_mvalid || i_m_axis_tready;
    assign rd_ok    = 32'(in_pos) < 32'(r_count);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_mvalid;
    assign o_m_axis_tdata  = r_mdata;

    skts_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer: next state, RAM access and result capture.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_key     = r_key;
        n_j       = r_j;
        n_lo      = r_lo;
        n_end     = r_end;
        n_mid     = r_mid;
        n_status  = r_status;
        n_fpos    = r_fpos;
        n_rkey    = r_rkey;
        ram_we    = 1'b0;
        ram_waddr = r_j[AW-1:0];
        ram_wdata = r_key;
        ram_raddr = mid[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                ram_raddr = AW'(in_pos);
                if (in_accept) begin
                    n_key    = in_key[KEY_BITS-1:0];
                    n_status = ST_OK;
                    n_fpos   = '0;
                    n_rkey   = '0;
                    n_j      = r_count;
                    n_lo     = '0;
                    n_end    = r_count;
                    unique case (in_cmd)
                        CMD_INSERT: begin
                            if (32'(r_count) >= CAPACITY) begin
                                n_status = ST_FULL;
                                n_state  = S_FIN;
                            end else begin
                                n_state  = S_INS_RD;
                            end
                        end
                        CMD_FIND: begin
                            n_state = S_FND_RD;
                        end
                        CMD_READ: begin
                            n_fpos = in_pos;
                            if (rd_ok) begin
                                n_state = S_RD_WAIT;
                            end else begin
                                n_status = ST_BAD_POS;
                                n_state  = S_FIN;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count = '0;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                // Bottom reached: the new key goes in the first slot.
                ram_raddr = AW'(r_j - {{(CW-1){1'b0}}, 1'b1});
                if (r_j == '0) begin
                    ram_we  = 1'b1;
                    n_fpos  = 6'(r_j);
                    n_count = r_count + {{(CW-1){1'b0}}, 1'b1};
                    n_state = S_FIN;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                // Entry below is not less than the key: move it up one slot.
                ram_we = 1'b1;
                if (ram_rdata >= r_key) begin
                    ram_wdata = ram_rdata;
                    n_j       = r_j - {{(CW-1){1'b0}}, 1'b1};
                    n_state   = S_INS_RD;
                end else begin
                    n_fpos  = 6'(r_j);
                    n_count = r_count + {{(CW-1){1'b0}}, 1'b1};
                    n_state = S_FIN;
                end
            end
            S_FND_RD: begin
                if (r_lo >= r_end) begin
                    n_status = ST_MISS;
                    n_state  = S_FIN;
                end else begin
                    n_mid   = mid;
                    n_state = S_FND_CMP;
                end
            end
            S_FND_CMP: begin
                if (r_key == ram_rdata) begin
                    n_fpos  = 6'(r_mid);
                    n_state = S_FIN;
                end else if (r_key < ram_rdata) begin
                    n_end   = r_mid;
                    n_state = S_FND_RD;
                end else begin
                    n_lo    = r_mid + {{(CW-1){1'b0}}, 1'b1};
                    n_state = S_FND_RD;
                end
            end
            S_RD_WAIT: begin
                n_rkey  = ram_rdata;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register load and release.
    always_comb begin
        n_mvalid = r_mvalid;
        n_mdata  = r_mdata;
        if (r_mvalid && i_m_axis_tready) begin
            n_mvalid = 1'b0;
        end
        if (r_state == S_FIN && out_free) begin
            n_mvalid = 1'b1;
            n_mdata  = {1'b0, 7'(r_count), 64'(r_rkey), r_fpos, r_status};
        end
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_mvalid <= n_mvalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_j      <= n_j;
        r_lo     <= n_lo;
        r_end    <= n_end;
        r_mid    <= n_mid;
        r_status <= n_status;
        r_fpos   <= n_fpos;
        r_rkey   <= n_rkey;
        r_mdata  <= n_mdata;
    end

`ifndef ASSERT_OFF
    // The entry count never exceeds the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("entry count above capacity");

    // A clear command empties the table on the next cycle.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_cmd == CMD_CLEAR) |=> (r_count == '0))
        else $error("clear did not empty the table");

    // Only a successful result may carry a nonzero read key.
    a_rkey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mvalid && r_mdata[1:0] != ST_OK) |-> (r_mdata[71:8] == '0))
        else $error("read key set on a failed result");

    // An insert that stops above a lower entry raises the count by exactly one.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_CMP && ram_rdata < r_key) |=>
            (r_count == $past(r_count) + {{(CW-1){1'b0}}, 1'b1}))
        else $error("insert count step wrong");
`endif

endmodule
